// ===== rtl/core/rsi_pkg.sv =====
// Shared types and constants for the relative strength index block.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package rsi_pkg;

    // Field widths of the request and result payloads.
    localparam int PRICE_W = 32;
    localparam int DIFF_W  = PRICE_W + 1;
    localparam int RSI_W   = 15;
    localparam int WLEN_W  = 7;

    // Default depth of the difference chain.
    localparam int MAX_WINDOW_DEF = 64;

    // Window length after reset.
    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST = 7'd14;

    // Full scale is 100 * 256 = (64 + 32 + 4) << 8.
    localparam int SCALE_SHIFT = 8;
    localparam int HUNDRED_W   = 7;

    // Largest legal result value.
    localparam logic [RSI_W-1:0] RSI_FULL_SCALE = 15'd25600;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               restart;
    } rsi_in_t;

    typedef struct packed {
        logic [RSI_W-1:0] rsi_value;
        logic             flat_window;
    } rsi_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsi_cell.sv =====
// One cell of the difference chain: holds one price difference and adds it
// into the gain or loss partial sum passing through. Depends on rsi_pkg.
`default_nettype none

module rsi_cell
    import rsi_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int SUM_W = PRICE_W + 6,
    parameter int CNT_W = 7
)
(
    input  wire logic                     clk,
    input  wire logic                     shift_en,
    input  wire logic signed [DIFF_W-1:0] diff_in,
    output logic signed [DIFF_W-1:0]      diff_out,
    input  wire logic [CNT_W-1:0]         length,
    input  wire logic [SUM_W-1:0]         gain_in,
    input  wire logic [SUM_W-1:0]         loss_in,
    output logic [SUM_W-1:0]              gain_out,
    output logic [SUM_W-1:0]              loss_out
);

    logic signed [DIFF_W-1:0] diff_reg;
    logic [SUM_W-1:0]         gain_reg;
    logic [SUM_W-1:0]         loss_reg;
    logic [SUM_W-1:0]         gain_next;
    logic [SUM_W-1:0]         loss_next;
    logic [DIFF_W-1:0]        mag;
    logic                     included;

    // The difference moves one place along the chain on each new sample.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            diff_reg <= diff_in;
        end
    end

    // Only the newest cells, up to the window length, take part in the sums.
    assign included = (CNT_W'(IDX) < length);
    assign mag      = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);

    always_comb
    begin
        gain_next = gain_in;
        loss_next = loss_in;
        if (included && (diff_reg > 0))
        begin
            gain_next = gain_in + SUM_W'(mag[PRICE_W-1:0]);
        end
        else if (included && (diff_reg < 0))
        begin
            loss_next = loss_in + SUM_W'(mag[PRICE_W-1:0]);
        end
    end

    // Partial sums are registered so that each cell adds one term per cycle.
    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
        loss_reg <= loss_next;
    end

    assign diff_out = diff_reg;
    assign gain_out = gain_reg;
    assign loss_out = loss_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rsi_div.sv =====
// Scales the gain sum by 25600 and divides it by the total, one quotient bit
// per cycle (restoring division). Depends on rsi_pkg.
`default_nettype none

module rsi_div
    import rsi_pkg::*;
#(
    parameter int SUM_W = PRICE_W + 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] gain,
    input  wire logic [SUM_W-1:0] total,
    output logic                  done,
    output rsi_out_t              res
);

    localparam int G100_W = SUM_W + HUNDRED_W;
    localparam int NUM_W  = G100_W + SCALE_SHIFT;
    localparam int STEP_W = $clog2(RSI_W);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rem_next;
    logic [RSI_W-1:0]  low_reg;
    logic [RSI_W-1:0]  low_next;
    logic [SUM_W-1:0]  den_reg;
    logic [SUM_W-1:0]  den_next;
    logic [RSI_W-1:0]  quo_reg;
    logic [RSI_W-1:0]  quo_next;
    logic              flat_reg;
    logic              flat_next;
    logic [G100_W-1:0] gain_ext;
    logic [G100_W-1:0] gain_x100;
    logic [NUM_W-1:0]  numer;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    trial_diff;

    // Numerator gain * 100 * 256, built from shifts and adds.
    assign gain_ext   = G100_W'(gain);
    assign gain_x100  = (gain_ext << 6) + (gain_ext << 5) + (gain_ext << 2);
    assign numer      = {gain_x100, {SCALE_SHIFT{1'b0}}};

    // One restoring step: bring down the next numerator bit and try to subtract.
    assign trial      = {rem_reg, low_reg[RSI_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        flat_next  = flat_reg;
        case (state_reg)
            D_IDLE,
            D_DONE:
            begin
                if (start)
                begin
                    den_next  = total;
                    step_next = '0;
                    quo_next  = '0;
                    // The quotient never exceeds 25600, so the top part of the
                    // numerator is already below the divisor.
                    rem_next  = numer[NUM_W-1:RSI_W];
                    low_next  = numer[RSI_W-1:0];
                    if (total == '0)
                    begin
                        flat_next  = 1'b1;
                        state_next = D_DONE;
                    end
                    else
                    begin
                        flat_next  = 1'b0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                low_next = {low_reg[RSI_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial_diff[SUM_W-1:0];
                    quo_next = {quo_reg[RSI_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SUM_W-1:0];
                    quo_next = {quo_reg[RSI_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(RSI_W - 1))
                begin
                    state_next = D_DONE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        flat_reg <= flat_next;
    end

    assign done            = (state_reg == D_DONE);
    assign res.rsi_value   = quo_reg;
    assign res.flat_window = flat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/relative_strength_index.sv =====
// Relative strength index over a window of price differences, Q.8 result.
// A request that yields no result is taken without a stall. One with a result stalls
// the input while the sums travel along the cell chain, while the serial divider
// runs and until the result register is free; the block takes no new request
// before that result has been loaded into the result register.
// rst_n clears control, the previous price, the window length (to 14) and the sample count.
`default_nettype none

module relative_strength_index
    import rsi_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire rsi_in_t           sample,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output rsi_out_t               result,
    input  wire logic              cfg_we,
    input  wire logic [WLEN_W-1:0] cfg_data
);

    localparam int SUM_W = PRICE_W + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   sum_cnt_reg;
    logic [CNT_W-1:0]   sum_cnt_next;
    logic [WLEN_W-1:0]  wlen_reg;
    logic [CNT_W-1:0]   len_reg;
    logic [CNT_W-1:0]   eff_len;
    logic [CNT_W-1:0]   seen_reg;
    logic [CNT_W-1:0]   seen_next;
    logic [CNT_W-1:0]   seen_base;
    logic [PRICE_W-1:0] prev_price_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    rsi_out_t           result_reg;
    logic               accept;
    logic               shift_en;
    logic               produce;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    rsi_out_t           div_res;
    logic [SUM_W-1:0]   total;

    logic signed [DIFF_W-1:0] diff_link [0:MAX_WINDOW];
    logic [SUM_W-1:0]         gain_link [0:MAX_WINDOW];
    logic [SUM_W-1:0]         loss_link [0:MAX_WINDOW];

    assign accept   = sample_valid && !sample_stall;
    assign out_free = !result_valid_reg || !result_stall;

    // Window length in use: zero counts as one, large values saturate.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (32'(wlen_reg) > MAX_WINDOW)
        begin
            eff_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = CNT_W'(wlen_reg);
        end
    end

    // Sample count of the current series, saturating at MAX_WINDOW + 1.
    assign seen_base = sample.restart ? '0 : seen_reg;
    assign shift_en  = accept && (seen_base != '0);
    assign seen_next = (seen_base == CNT_W'(MAX_WINDOW + 1)) ? seen_base
                                                             : seen_base + 1'b1;
    // A result is due once the differences held reach the window length.
    assign produce   = seen_next > eff_len;

    // Newest difference enters the head of the chain.
    assign diff_link[0] = $signed({1'b0, sample.price}) - $signed({1'b0, prev_price_reg});
    assign gain_link[0] = '0;
    assign loss_link[0] = '0;

    // Chain of cells: differences shift along it, partial sums flow through it.
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        rsi_cell #(
            .IDX   (i),
            .SUM_W (SUM_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .diff_in  (diff_link[i]),
            .diff_out (diff_link[i+1]),
            .length   (len_reg),
            .gain_in  (gain_link[i]),
            .loss_in  (loss_link[i]),
            .gain_out (gain_link[i+1]),
            .loss_out (loss_link[i+1])
        );
    end

    assign total = gain_link[MAX_WINDOW] + loss_link[MAX_WINDOW];

    // Sequencer: wait for the sums to reach the chain's end, divide, then load the result once the output is free.
    always_comb
    begin
        state_next        = state_reg;
        sum_cnt_next      = sum_cnt_reg;
        result_valid_next = result_valid_reg && result_stall;
        div_start         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && produce)
                begin
                    sum_cnt_next = '0;
                    state_next   = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_cnt_next = sum_cnt_reg + 1'b1;
                if (sum_cnt_reg == CNT_W'(MAX_WINDOW))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done && out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    rsi_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .gain  (gain_link[MAX_WINDOW]),
        .total (total),
        .done  (div_done),
        .res   (div_res)
    );

    // Control and series state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sum_cnt_reg      <= '0;
            wlen_reg         <= WINDOW_LENGTH_RST;
            seen_reg         <= '0;
            prev_price_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_cnt_reg      <= sum_cnt_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                wlen_reg <= cfg_data;
            end
            if (accept)
            begin
                seen_reg       <= seen_next;
                prev_price_reg <= sample.price;
            end
        end
    end

    // Window length latched per request, and the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg <= eff_len;
        end
        if ((state_reg == S_DIV) && div_done && out_free)
        begin
            result_reg <= div_res;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A flat window always reports zero.
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.flat_window) |-> (result.rsi_value == '0))
        else $error("flat window with nonzero value");

    // The value never exceeds full scale.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.rsi_value <= RSI_FULL_SCALE))
        else $error("result above full scale");

    // A new result only appears out of the divide phase.
    a_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_DIV))
        else $error("result raised outside divide phase");

    // The sum counter stays within the chain depth.
    a_sum_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (sum_cnt_reg <= CNT_W'(MAX_WINDOW)))
        else $error("sum counter overran chain");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for relative_strength_index: drives price samples,
// predicts each RSI result in its own model and compares it field by field.
// Depends on rsi_pkg and the relative_strength_index top level only.
`timescale 1ns / 100ps

module tb_top;

    import rsi_pkg::*;

    // Depth of the difference history, matching the block's default.
    localparam int WINDOW_DEPTH = MAX_WINDOW_DEF;
    // Cycles for one request with a result to pass through the block, with margin.
    localparam int SETTLE_CYCLES = WINDOW_DEPTH + 40;
    // Cycles the receiver holds off during the backpressure test.
    localparam int LONG_HOLD_CYCLES = 600;
    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Mismatch lines printed before the rest are only counted.
    localparam int MAX_REPORTS = 50;

    logic                clk;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_stall;
    rsi_in_t             sample;
    logic                result_valid;
    logic                result_stall;
    rsi_out_t            result;
    logic                cfg_we;
    logic [WLEN_W-1:0]   cfg_data;

    // Shared state between the stimulus, the receiver and the checker.
    rsi_out_t            pending_rsi[$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    bit                  no_idle = 1'b0;
    bit                  hold_request = 1'b0;
    int                  hold_left = 0;

    // Predictor state: its own copy of the window register and price history.
    logic [WLEN_W-1:0]          window_reg = WINDOW_LENGTH_RST;
    logic [PRICE_W-1:0]         last_price = '0;
    logic signed [DIFF_W-1:0]   price_diffs[WINDOW_DEPTH];
    int                         series_count = 0;

    relative_strength_index uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung block must not hang the run.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Updates the price history for one accepted request and queues the
    // RSI it should produce, if the series is past its warm-up.
    task automatic compute_rsi(input rsi_in_t item);
        int                 span;
        logic signed [63:0] step_diff;
        logic [63:0]        gains;
        logic [63:0]        losses;
        logic [63:0]        total;
        rsi_out_t           want;
        span = (window_reg == 0) ? 1 : ((window_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : window_reg);
        if (item.restart)
            series_count = 0;
        if (series_count > 0)
        begin
            for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                price_diffs[i] = price_diffs[i - 1];
            price_diffs[0] = $signed({1'b0, item.price}) - $signed({1'b0, last_price});
        end
        last_price = item.price;
        if (series_count < WINDOW_DEPTH + 1)
            series_count++;
        // Warm-up: not enough differences held for the current length.
        if (series_count - 1 < span)
            return;
        gains = '0;
        losses = '0;
        for (int i = 0; i < span; i++)
        begin
            step_diff = price_diffs[i];
            if (step_diff > 0)
                gains += step_diff;
            else if (step_diff < 0)
                losses += -step_diff;
        end
        total = gains + losses;
        if (total == 0)
        begin
            want.rsi_value = '0;
            want.flat_window = 1'b1;
        end
        else
        begin
            want.rsi_value = RSI_W'((gains * 64'(RSI_FULL_SCALE)) / total);
            want.flat_window = 1'b0;
        end
        pending_rsi.push_back(want);
    endtask

    // Compares one accepted result with the oldest expectation.
    task automatic check_result(input rsi_out_t got);
        rsi_out_t want;
        if (pending_rsi.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result rsi_value=%0d flat_window=%0b",
                                      got.rsi_value, got.flat_window));
            return;
        end
        want = pending_rsi.pop_front();
        if (got.rsi_value !== want.rsi_value)
            report_mismatch($sformatf("rsi_value %0d, expected %0d",
                                      got.rsi_value, want.rsi_value));
        if (got.flat_window !== want.flat_window)
            report_mismatch($sformatf("flat_window %0b, expected %0b",
                                      got.flat_window, want.flat_window));
    endtask

    // Result checker: samples the result channel at each rising edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                check_result(result);
        end
    end

    // Receiver: random stalls, none in the quiet stretch, and a long hold
    // on request that is counted down here.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !no_idle && ($urandom_range(99) < 32);
        end
    end

    // Offers one request, with random gaps before it, and waits until it is
    // taken. Called at a falling edge; returns at a falling edge with valid
    // still high, so back-to-back requests never drop valid.
    task automatic send_sample(input rsi_in_t item);
        while (!no_idle && ($urandom_range(99) < 32))
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= item;
        do
            @(posedge clk);
        while (sample_stall);
        compute_rsi(item);
        @(negedge clk);
    endtask

    // Writes the window length once every expected result has come and the
    // block has had time to finish any request that yields none.
    task automatic set_window(input logic [WLEN_W-1:0] length);
        sample_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsi.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= length;
        @(negedge clk);
        cfg_we <= 1'b0;
        window_reg = length;
    endtask

    // Random price series: runs of random walks, flat stretches, one-way
    // moves, large jumps, extremes and pure noise, with occasional restarts.
    task automatic run_series(input int count, input int restart_odds);
        rsi_in_t            item;
        logic [PRICE_W-1:0] level;
        int                 mode;
        int                 run_left;
        level = $urandom;
        mode = 0;
        run_left = 0;
        repeat (count)
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(10);
                run_left = $urandom_range(1, 40);
            end
            run_left--;
            case (mode)
                0, 1, 2, 3, 4: level = level + $urandom_range(2000) - 1000;
                5:             level = level;
                6:             level = level + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
                7:             level = $urandom;
                8:             level = $urandom_range(1) ? '1 : '0;
                9:             level = level + $urandom_range(500);
                default:       level = level - $urandom_range(500);
            endcase
            item.price = level;
            item.restart = ($urandom_range(restart_odds - 1) == 0);
            send_sample(item);
        end
    endtask

    // Reset window length, restart on the very first sample, warm-up of 15.
    task automatic test_default_window();
        rsi_in_t item;
        for (int k = 0; k < 15; k++)
        begin
            item.price = (k % 3 == 0) ? 32'(1000 - k * 7) : 32'(1000 + k * 13);
            item.restart = (k == 0);
            send_sample(item);
        end
    endtask

    // Length zero acts as one: full-scale rise, full-scale fall, a flat
    // window and a gain with no loss.
    task automatic test_extreme_moves();
        rsi_in_t item;
        set_window('0);
        item.restart = 1'b1;
        item.price = '0;
        send_sample(item);
        item.restart = 1'b0;
        item.price = '1;
        send_sample(item);
        item.price = '0;
        send_sample(item);
        send_sample(item);
        item.price = 32'd7;
        send_sample(item);
    endtask

    // Length grows within a series, then a restart goes through warm-up again.
    task automatic test_window_change_mid_series();
        rsi_in_t item;
        set_window(7'd2);
        item.restart = 1'b0;
        item.price = 32'd3;
        send_sample(item);
        send_sample(item);
        item.restart = 1'b1;
        item.price = '1;
        send_sample(item);
        item.restart = 1'b0;
        item.price = 32'hFFFF_FFFE;
        send_sample(item);
        item.price = '1;
        send_sample(item);
    endtask

    // Random series over a spread of window lengths, extremes included.
    task automatic test_random_windows();
        logic [WLEN_W-1:0] lengths[7];
        lengths = '{7'd1, 7'd64, 7'd127, 7'd3, 7'd65, 7'd14, 7'($urandom_range(127))};
        foreach (lengths[i])
        begin
            set_window(lengths[i]);
            run_series(160, (lengths[i] >= 20) ? 500 : 50);
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        set_window(7'd8);
        hold_request = 1'b1;
        run_series(160, 50);
    endtask

    // The sender stops half way until every expected result has come.
    task automatic test_sender_drain_pause();
        set_window(7'd5);
        run_series(80, 50);
        sample_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsi.size() != 0);
        run_series(80, 50);
    endtask

    // A stretch with no idling on either side.
    task automatic test_no_idle_stretch();
        set_window(7'($urandom_range(1, 20)));
        no_idle = 1'b1;
        run_series(160, 40);
        no_idle = 1'b0;
    endtask

    // Reset, the tests in turn, then the drain and the verdict.
    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_window();
        test_extreme_moves();
        test_window_change_mid_series();
        test_random_windows();
        test_output_backpressure();
        test_sender_drain_pause();
        test_no_idle_stretch();

        sample_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsi.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_rsi.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_rsi.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rsi_pkg.sv
rtl/core/rsi_cell.sv
rtl/core/rsi_div.sv
rtl/core/relative_strength_index.sv
dv/tb_top.sv
